// File: design/mtep_pkg.sv
// Package for the MIDI track event parser: parse phase and event kind codes,
// the parser state and result types, and the result builder function.
// No dependencies.
`timescale 1ns / 1ps

package mtep_pkg;

  localparam int PhaseW = 4;

  localparam logic [PhaseW-1:0] PH_DELTA    = 4'd0;
  localparam logic [PhaseW-1:0] PH_STATUS   = 4'd1;
  localparam logic [PhaseW-1:0] PH_DATA1    = 4'd2;
  localparam logic [PhaseW-1:0] PH_DATA2    = 4'd3;
  localparam logic [PhaseW-1:0] PH_SYSLEN   = 4'd4;
  localparam logic [PhaseW-1:0] PH_SKIP     = 4'd5;
  localparam logic [PhaseW-1:0] PH_METATYPE = 4'd6;
  localparam logic [PhaseW-1:0] PH_METALEN  = 4'd7;
  localparam logic [PhaseW-1:0] PH_TEMPO    = 4'd8;
  localparam logic [PhaseW-1:0] PH_ENDED    = 4'd9;

  localparam logic [2:0] KIND_NOTE_OFF = 3'd0;
  localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
  localparam logic [2:0] KIND_OTHER    = 3'd2;
  localparam logic [2:0] KIND_TEMPO    = 3'd3;
  localparam logic [2:0] KIND_END      = 3'd4;

  localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
  localparam logic [3:0] HI_NOTE_ON   = 4'h9;
  localparam logic [3:0] HI_PROGRAM   = 4'hC;
  localparam logic [3:0] HI_PRESSURE  = 4'hD;

  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [7:0] META_END     = 8'h2F;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [7:0]        running_status;
    logic [27:0]       delta_accum;
    logic [27:0]       length_accum;
    logic [6:0]        first_data;
    logic [7:0]        meta_type;
    logic [1:0]        body_count;
    logic [23:0]       tempo_value;
    logic              tempo_seen;
    logic [31:0]       wall_time;
  } parse_state_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [6:0]  pitch;
    logic [6:0]  velocity;
    logic [27:0] delta_ticks;
    logic [31:0] abs_ticks;
    logic [23:0] tempo_usec;
  } event_t;

  function automatic event_t make_event(parse_state_t st, logic [2:0] kind,
                                        logic [6:0] p, logic [6:0] v);
    event_t ev;
    ev.event_kind  = kind;
    ev.pitch       = p;
    ev.velocity    = v;
    ev.delta_ticks = st.delta_accum;
    ev.abs_ticks   = st.wall_time;
    ev.tempo_usec  = st.tempo_seen ? st.tempo_value : 24'd0;
    return ev;
  endfunction

endpackage

// File: design/mtep_step.sv
// Next-state and result logic of the MIDI track event parser for one byte.
// Depends on mtep_pkg.
`timescale 1ns / 1ps

module mtep_step (
  input  mtep_pkg::parse_state_t cur,
  input  logic [7:0]             data_byte,
  input  logic                   track_start,
  output mtep_pkg::parse_state_t nxt,
  output logic                   emit,
  output mtep_pkg::event_t       ev
);

  always_comb begin
    mtep_pkg::parse_state_t st;
    logic       data1;
    logic       done;
    logic [6:0] d2;
    logic [3:0] hi;

    st    = cur;
    data1 = 1'b0;
    done  = 1'b0;
    d2    = 7'd0;
    emit  = 1'b0;
    ev    = mtep_pkg::make_event(cur, mtep_pkg::KIND_OTHER, 7'd0, 7'd0);

    if (track_start) begin
      st.phase          = mtep_pkg::PH_DELTA;
      st.delta_accum    = 28'd0;
      st.length_accum   = 28'd0;
      st.body_count     = 2'd0;
      st.running_status = 8'd0;
      st.wall_time      = 32'd0;
      if (!st.tempo_seen) begin
        st.tempo_value = 24'd0;
      end
    end

    case (st.phase)
      mtep_pkg::PH_STATUS: begin
        if (data_byte[7]) begin
          st.running_status = 8'd0;
          if (data_byte < mtep_pkg::ST_SYSEX) begin
            st.running_status = data_byte;
            st.phase          = mtep_pkg::PH_DATA1;
          end else if (data_byte == mtep_pkg::ST_SYSEX ||
                       data_byte == mtep_pkg::ST_SYSEX_ESC) begin
            st.phase = mtep_pkg::PH_SYSLEN;
          end else if (data_byte == mtep_pkg::ST_META) begin
            st.phase = mtep_pkg::PH_METATYPE;
          end else begin
            st.phase        = mtep_pkg::PH_DELTA;
            st.delta_accum  = 28'd0;
            st.length_accum = 28'd0;
            st.body_count   = 2'd0;
          end
        end else if (st.running_status == 8'd0) begin
          st.phase        = mtep_pkg::PH_DELTA;
          st.delta_accum  = 28'd0;
          st.length_accum = 28'd0;
          st.body_count   = 2'd0;
        end else begin
          data1 = 1'b1;
        end
      end
      mtep_pkg::PH_DATA1: begin
        data1 = 1'b1;
      end
      mtep_pkg::PH_DATA2: begin
        done = 1'b1;
        d2   = data_byte[6:0];
      end
      mtep_pkg::PH_SYSLEN: begin
        st.length_accum = {st.length_accum[20:0], data_byte[6:0]};
        if (!data_byte[7]) begin
          if (st.length_accum == 28'd0) begin
            st.phase      = mtep_pkg::PH_DELTA;
            st.delta_accum = 28'd0;
            st.body_count  = 2'd0;
          end else begin
            st.phase = mtep_pkg::PH_SKIP;
          end
        end
      end
      mtep_pkg::PH_SKIP: begin
        st.length_accum = st.length_accum - 28'd1;
        if (st.length_accum == 28'd0) begin
          st.phase       = mtep_pkg::PH_DELTA;
          st.delta_accum = 28'd0;
          st.body_count  = 2'd0;
        end
      end
      mtep_pkg::PH_METATYPE: begin
        st.meta_type    = data_byte;
        st.length_accum = 28'd0;
        st.phase        = mtep_pkg::PH_METALEN;
      end
      mtep_pkg::PH_METALEN: begin
        st.length_accum = {st.length_accum[20:0], data_byte[6:0]};
        if (!data_byte[7]) begin
          if (st.meta_type == mtep_pkg::META_END) begin
            emit     = 1'b1;
            ev       = mtep_pkg::make_event(st, mtep_pkg::KIND_END, 7'd0, 7'd0);
            st.phase = mtep_pkg::PH_ENDED;
          end else if (st.meta_type == mtep_pkg::META_TEMPO && !st.tempo_seen &&
                       st.length_accum >= 28'd3) begin
            st.tempo_value = 24'd0;
            st.body_count  = 2'd0;
            st.phase       = mtep_pkg::PH_TEMPO;
          end else if (st.length_accum == 28'd0) begin
            st.phase       = mtep_pkg::PH_DELTA;
            st.delta_accum = 28'd0;
            st.body_count  = 2'd0;
          end else begin
            st.phase = mtep_pkg::PH_SKIP;
          end
        end
      end
      mtep_pkg::PH_TEMPO: begin
        st.tempo_value  = {st.tempo_value[15:0], data_byte};
        st.length_accum = st.length_accum - 28'd1;
        st.body_count   = st.body_count + 2'd1;
        if (st.body_count == 2'd3) begin
          st.tempo_seen = 1'b1;
          emit          = 1'b1;
          ev            = mtep_pkg::make_event(st, mtep_pkg::KIND_TEMPO, 7'd0, 7'd0);
          if (st.length_accum == 28'd0) begin
            st.phase       = mtep_pkg::PH_DELTA;
            st.delta_accum = 28'd0;
            st.body_count  = 2'd0;
          end else begin
            st.phase = mtep_pkg::PH_SKIP;
          end
        end
      end
      mtep_pkg::PH_ENDED: begin
        st.phase = mtep_pkg::PH_ENDED;
      end
      default: begin
        st.delta_accum = {st.delta_accum[20:0], data_byte[6:0]};
        if (!data_byte[7]) begin
          st.wall_time = st.wall_time + {4'd0, st.delta_accum};
          st.phase     = mtep_pkg::PH_STATUS;
        end else begin
          st.phase = mtep_pkg::PH_DELTA;
        end
      end
    endcase

    hi = st.running_status[7:4];

    if (data1) begin
      st.first_data = data_byte[6:0];
      if (hi == mtep_pkg::HI_PROGRAM || hi == mtep_pkg::HI_PRESSURE) begin
        done = 1'b1;
      end else begin
        st.phase = mtep_pkg::PH_DATA2;
      end
    end

    if (done) begin
      case (hi)
        mtep_pkg::HI_NOTE_OFF: begin
          emit = 1'b1;
          ev   = mtep_pkg::make_event(st, mtep_pkg::KIND_NOTE_OFF, st.first_data, d2);
        end
        mtep_pkg::HI_NOTE_ON: begin
          emit = 1'b1;
          ev   = mtep_pkg::make_event(st, (d2 == 7'd0) ? mtep_pkg::KIND_NOTE_OFF :
                                      mtep_pkg::KIND_NOTE_ON, st.first_data, d2);
        end
        mtep_pkg::HI_PRESSURE: begin
          emit = 1'b0;
        end
        default: begin
          emit = 1'b1;
          ev   = mtep_pkg::make_event(st, mtep_pkg::KIND_OTHER, 7'd0, 7'd0);
        end
      endcase
      st.phase        = mtep_pkg::PH_DELTA;
      st.delta_accum  = 28'd0;
      st.length_accum = 28'd0;
      st.body_count   = 2'd0;
    end

    nxt = st;
  end

endmodule

// File: design/midi_track_event_parser.sv
// Top level of the MIDI track event parser: handshakes, parser state and
// result register. Depends on mtep_pkg and mtep_step.
`timescale 1ns / 1ps

// The parser takes one track byte per transfer and can take a new byte in
// every clock cycle unless the output stalls, so a track streams at one byte
// per cycle. Each byte is parsed in the cycle it is accepted and any event it
// completes appears in the result register on the next cycle. The input is
// held off only while a finished event waits in the result register and the
// output side is stalled. Raise track_start with the first byte of each
// track; a captured tempo is kept across tracks and is cleared only by reset.
module midi_track_event_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        track_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_kind,
  output logic [6:0]  pitch,
  output logic [6:0]  velocity,
  output logic [27:0] delta_ticks,
  output logic [31:0] abs_ticks,
  output logic [23:0] tempo_usec
);

  mtep_pkg::parse_state_t st;
  mtep_pkg::parse_state_t st_next;
  mtep_pkg::event_t       ev_next;
  mtep_pkg::event_t       result;
  logic                   emit;
  logic                   in_fire;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  mtep_step u_step (
    .cur         (st),
    .data_byte   (data_byte),
    .track_start (track_start),
    .nxt         (st_next),
    .emit        (emit),
    .ev          (ev_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        st <= st_next;
      end
      if (in_fire) begin
        out_valid <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      result <= ev_next;
    end
  end

  assign event_kind  = result.event_kind;
  assign pitch       = result.pitch;
  assign velocity    = result.velocity;
  assign delta_ticks = result.delta_ticks;
  assign abs_ticks   = result.abs_ticks;
  assign tempo_usec  = result.tempo_usec;

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_kind <= mtep_pkg::KIND_END)
    else $error("event kind out of range");

  a_no_note_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind != mtep_pkg::KIND_NOTE_OFF &&
     event_kind != mtep_pkg::KIND_NOTE_ON) |-> (pitch == 7'd0 && velocity == 7'd0))
    else $error("pitch or velocity set on a non-note event");

  a_ended_silent: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !track_start && st.phase == mtep_pkg::PH_ENDED) |=>
      (!out_valid && st.phase == mtep_pkg::PH_ENDED))
    else $error("event produced after end of track");

  a_tempo_seen: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tempo_usec != 24'd0) |-> st.tempo_seen)
    else $error("tempo reported before capture");

endmodule
